/* design/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SETUP = 3'd1,
    PH_RISE  = 3'd2,
    PH_HIGH  = 3'd3,
    PH_MID   = 3'd4
  } phase_t;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  localparam logic [1:0] REG_HALF_PERIOD    = 2'd0;
  localparam logic [1:0] REG_QUARTER_PERIOD = 2'd1;
  localparam logic [1:0] REG_STRETCH_LIMIT  = 2'd2;

  localparam int DELAY_W   = 16;
  localparam int STRETCH_W = 20;
  localparam int BYTE_W    = 8;
  localparam int BITCNT_W  = 4;

  localparam logic [BITCNT_W-1:0]  BITS_PER_BYTE     = 4'd8;
  localparam logic [DELAY_W-1:0]   HALF_RESET        = 16'd22;
  localparam logic [DELAY_W-1:0]   QUARTER_RESET     = 16'd11;
  localparam logic [STRETCH_W-1:0] STRETCH_RESET     = 20'd100000;

  typedef struct packed {
    logic [DELAY_W-1:0]   half_period_ticks;
    logic [DELAY_W-1:0]   quarter_period_ticks;
    logic [STRETCH_W-1:0] stretch_limit;
  } cfg_t;

  typedef struct packed {
    logic              scl_drive;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
    logic              slave_nak;
    logic              stretch_timeout;
  } res_t;

endpackage

/* design/i2c_master_byte_engine.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine
// Top level: configuration registers, sequencer and output register.
// ----------------------------------------------------------------------------
// Each request is one tick of the bus timing and yields exactly one result.
// The engine takes one request per clock cycle; the sequencer state and the
// result are both computed in that single cycle, and the result sits in an
// output register so a new request is taken while the previous result is
// taken. Requests are held off only while a result waits under stall.
module i2c_master_byte_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           cmd_valid,
  input  logic [1:0]                     opcode,
  input  logic [i2cm_pkg::BYTE_W-1:0]    write_byte,
  input  logic                           scl_sense,
  input  logic                           sda_sense,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           scl_drive,
  output logic                           sda_drive,
  output logic                           busy_res,
  output logic                           done_res,
  output logic [i2cm_pkg::BYTE_W-1:0]    read_byte,
  output logic                           slave_nak,
  output logic                           stretch_timeout,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [i2cm_pkg::STRETCH_W-1:0] cfg_data
);

  i2cm_pkg::cfg_t cfg;
  i2cm_pkg::res_t res_comb;
  i2cm_pkg::res_t res_q;
  logic           acc;

  assign in_stall = out_valid && out_stall;
  assign acc      = in_valid && !in_stall;

  i2cm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cm_core u_core (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .opcode     (opcode),
    .write_byte (write_byte),
    .scl_sense  (scl_sense),
    .sda_sense  (sda_sense),
    .res        (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) res_q <= res_comb;
  end

  assign scl_drive       = res_q.scl_drive;
  assign sda_drive       = res_q.sda_drive;
  assign busy_res        = res_q.busy_res;
  assign done_res        = res_q.done_res;
  assign read_byte       = res_q.read_byte;
  assign slave_nak       = res_q.slave_nak;
  assign stretch_timeout = res_q.stretch_timeout;

endmodule

/* design/i2cm_cfg.sv */
// ----------------------------------------------------------------------------
// I2C master configuration registers
// Holds the timing registers written through the plain write port.
// ----------------------------------------------------------------------------
module i2cm_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [i2cm_pkg::STRETCH_W-1:0] cfg_data,
  output i2cm_pkg::cfg_t              cfg
);

  i2cm_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.half_period_ticks    <= i2cm_pkg::HALF_RESET;
      regs.quarter_period_ticks <= i2cm_pkg::QUARTER_RESET;
      regs.stretch_limit        <= i2cm_pkg::STRETCH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cm_pkg::REG_HALF_PERIOD: begin
          regs.half_period_ticks <= cfg_data[i2cm_pkg::DELAY_W-1:0];
        end
        i2cm_pkg::REG_QUARTER_PERIOD: begin
          regs.quarter_period_ticks <= cfg_data[i2cm_pkg::DELAY_W-1:0];
        end
        i2cm_pkg::REG_STRETCH_LIMIT: begin
          regs.stretch_limit <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

/* design/i2cm_core.sv */
// ----------------------------------------------------------------------------
// I2C master sequencer
// Advances the bus sequence by one tick per accepted request and forms the
// result of that tick from the updated state.
// ----------------------------------------------------------------------------
module i2cm_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        acc,
  input  i2cm_pkg::cfg_t              cfg,
  input  logic                        cmd_valid,
  input  logic [1:0]                  opcode,
  input  logic [i2cm_pkg::BYTE_W-1:0] write_byte,
  input  logic                        scl_sense,
  input  logic                        sda_sense,
  output i2cm_pkg::res_t              res
);

  i2cm_pkg::phase_t                  phase, phase_next;
  logic [1:0]                        current_op, current_op_next;
  logic [i2cm_pkg::BITCNT_W-1:0]     bit_count, bit_count_next;
  logic [i2cm_pkg::BYTE_W-1:0]       shift_reg, shift_reg_next;
  logic [i2cm_pkg::DELAY_W-1:0]      delay_count, delay_count_next;
  logic [i2cm_pkg::STRETCH_W-1:0]    stretch_count, stretch_count_next;
  logic                              scl_level, scl_level_next;
  logic                              sda_level, sda_level_next;
  logic [i2cm_pkg::BYTE_W-1:0]       received_byte, received_byte_next;
  logic                              nak_flag, nak_flag_next;
  logic                              timeout_flag, timeout_flag_next;

  logic                              delay_done;
  logic [i2cm_pkg::DELAY_W-1:0]      delay_dec;
  logic [i2cm_pkg::DELAY_W-1:0]      half_load;
  logic [i2cm_pkg::DELAY_W-1:0]      quarter_load;
  logic [i2cm_pkg::STRETCH_W-1:0]    limit;
  logic [i2cm_pkg::STRETCH_W-1:0]    stretch_inc;
  logic                              stretch_over;
  logic                              rise_go;
  logic                              framing;
  logic [i2cm_pkg::BITCNT_W-1:0]     bit_inc;
  logic                              byte_end;
  logic [i2cm_pkg::BYTE_W-1:0]       shifted;
  logic                              done;

  function automatic logic drive_level(input logic [i2cm_pkg::BITCNT_W-1:0] bc,
                                       input logic [1:0] op,
                                       input logic [i2cm_pkg::BYTE_W-1:0] sr);
    logic lvl;
    if (bc >= i2cm_pkg::BITS_PER_BYTE) begin
      lvl = (op != i2cm_pkg::OP_READ);
    end else if (op == i2cm_pkg::OP_READ) begin
      lvl = 1'b1;
    end else begin
      lvl = sr[i2cm_pkg::BYTE_W-1];
    end
    return lvl;
  endfunction

  assign delay_done   = (delay_count <= i2cm_pkg::DELAY_W'(1));
  assign delay_dec    = delay_done ? '0 : delay_count - i2cm_pkg::DELAY_W'(1);
  assign half_load    = (cfg.half_period_ticks == '0) ? i2cm_pkg::DELAY_W'(1)
                                                      : cfg.half_period_ticks;
  assign quarter_load = (cfg.quarter_period_ticks == '0) ? i2cm_pkg::DELAY_W'(1)
                                                         : cfg.quarter_period_ticks;
  assign limit        = (cfg.stretch_limit == '0) ? i2cm_pkg::STRETCH_W'(1)
                                                  : cfg.stretch_limit;
  assign stretch_inc  = stretch_count + i2cm_pkg::STRETCH_W'(1);
  assign stretch_over = !scl_sense && (stretch_inc >= limit);
  assign rise_go      = scl_sense || stretch_over;
  assign framing      = (current_op == i2cm_pkg::OP_START) ||
                        (current_op == i2cm_pkg::OP_STOP);
  assign bit_inc      = bit_count + i2cm_pkg::BITCNT_W'(1);
  assign byte_end     = (bit_inc > i2cm_pkg::BITS_PER_BYTE);
  assign shifted      = {shift_reg[i2cm_pkg::BYTE_W-2:0],
                         (current_op == i2cm_pkg::OP_READ) & sda_sense};

  always_comb begin
    phase_next = phase;
    case (phase)
      i2cm_pkg::PH_SETUP: begin
        if (delay_done) phase_next = i2cm_pkg::PH_RISE;
      end
      i2cm_pkg::PH_RISE: begin
        if (rise_go) phase_next = i2cm_pkg::PH_HIGH;
      end
      i2cm_pkg::PH_HIGH: begin
        if (delay_done) begin
          if (framing) begin
            phase_next = i2cm_pkg::PH_MID;
          end else if (byte_end) begin
            phase_next = i2cm_pkg::PH_IDLE;
          end else begin
            phase_next = i2cm_pkg::PH_SETUP;
          end
        end
      end
      i2cm_pkg::PH_MID: begin
        if (delay_done) phase_next = i2cm_pkg::PH_IDLE;
      end
      default: begin
        phase_next = cmd_valid ? i2cm_pkg::PH_SETUP : i2cm_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    current_op_next    = current_op;
    bit_count_next     = bit_count;
    shift_reg_next     = shift_reg;
    delay_count_next   = delay_count;
    stretch_count_next = stretch_count;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    received_byte_next = received_byte;
    nak_flag_next      = nak_flag;
    timeout_flag_next  = timeout_flag;
    done               = 1'b0;
    case (phase)
      i2cm_pkg::PH_SETUP: begin
        delay_count_next = delay_dec;
        if (delay_done) begin
          scl_level_next     = 1'b1;
          stretch_count_next = '0;
        end
      end
      i2cm_pkg::PH_RISE: begin
        if (!scl_sense) stretch_count_next = stretch_inc;
        if (stretch_over) timeout_flag_next = 1'b1;
        if (rise_go) delay_count_next = framing ? quarter_load : half_load;
      end
      i2cm_pkg::PH_HIGH: begin
        delay_count_next = delay_dec;
        if (delay_done) begin
          if (framing) begin
            sda_level_next   = (current_op == i2cm_pkg::OP_STOP);
            delay_count_next = quarter_load;
          end else begin
            if (bit_count < i2cm_pkg::BITS_PER_BYTE) begin
              shift_reg_next = shifted;
            end else if (current_op == i2cm_pkg::OP_WRITE) begin
              nak_flag_next = sda_sense;
            end
            scl_level_next = 1'b0;
            if (byte_end) begin
              if (current_op == i2cm_pkg::OP_READ) received_byte_next = shift_reg;
              bit_count_next = '0;
              done           = 1'b1;
            end else begin
              bit_count_next   = bit_inc;
              sda_level_next   = drive_level(bit_inc, current_op,
                                   (bit_count < i2cm_pkg::BITS_PER_BYTE) ? shifted
                                                                        : shift_reg);
              delay_count_next = half_load;
            end
          end
        end
      end
      i2cm_pkg::PH_MID: begin
        delay_count_next = delay_dec;
        if (delay_done) begin
          scl_level_next = 1'b0;
          done           = 1'b1;
        end
      end
      default: begin
        if (cmd_valid) begin
          current_op_next    = opcode;
          bit_count_next     = '0;
          stretch_count_next = '0;
          delay_count_next   = half_load;
          if (opcode == i2cm_pkg::OP_START) begin
            sda_level_next = 1'b1;
          end else if (opcode == i2cm_pkg::OP_STOP) begin
            sda_level_next = 1'b0;
          end else begin
            shift_reg_next = (opcode == i2cm_pkg::OP_WRITE) ? write_byte : '0;
            sda_level_next = drive_level('0, opcode,
                               (opcode == i2cm_pkg::OP_WRITE) ? write_byte : '0);
          end
        end
      end
    endcase
  end

  always_comb begin
    res.scl_drive       = scl_level_next;
    res.sda_drive       = sda_level_next;
    res.busy_res        = (phase_next != i2cm_pkg::PH_IDLE);
    res.done_res        = done;
    res.read_byte       = received_byte_next;
    res.slave_nak       = nak_flag_next;
    res.stretch_timeout = timeout_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2cm_pkg::PH_IDLE;
      current_op    <= '0;
      bit_count     <= '0;
      shift_reg     <= '0;
      delay_count   <= '0;
      stretch_count <= '0;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      received_byte <= '0;
      nak_flag      <= 1'b0;
      timeout_flag  <= 1'b0;
    end else if (acc) begin
      phase         <= phase_next;
      current_op    <= current_op_next;
      bit_count     <= bit_count_next;
      shift_reg     <= shift_reg_next;
      delay_count   <= delay_count_next;
      stretch_count <= stretch_count_next;
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
      received_byte <= received_byte_next;
      nak_flag      <= nak_flag_next;
      timeout_flag  <= timeout_flag_next;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (acc && done) |=> (phase == i2cm_pkg::PH_IDLE))
    else $error("completion did not return the sequencer to idle");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= i2cm_pkg::BITS_PER_BYTE)
    else $error("bit counter beyond the acknowledge bit");

  a_rise_released: assert property (@(posedge clk) disable iff (rst)
    (phase == i2cm_pkg::PH_RISE || phase == i2cm_pkg::PH_HIGH) |-> scl_level)
    else $error("SCL held low while waiting for or holding the high level");

  a_timeout_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(timeout_flag))
    else $error("stretch timeout flag cleared outside reset");
`endif

endmodule

/* test/i2c_master_byte_engine_tb.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Drives one request per bus tick with start, stop, read and write commands
// and mimics the slave side: clock stretching on SCL, data and ACK/NAK bits
// on SDA. A cycle-accurate model of the engine predicts the pin levels and
// status of every tick, and each returned result is compared field by field.
// Both handshakes idle at random, and the delay registers are swept from
// zero up to a few dozen ticks, with the stretch limit also taken to its
// widest value, between bursts of traffic.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_tb;

  typedef struct packed {
    logic       cv;
    logic [1:0] op;
    logic [7:0] wb;
    logic       scl;
    logic       sda;
  } pin_tick_t;

  class engine_model;
    logic [i2cm_pkg::DELAY_W-1:0]   half_q;
    logic [i2cm_pkg::DELAY_W-1:0]   quarter_q;
    logic [i2cm_pkg::STRETCH_W-1:0] stretch_q;
    i2cm_pkg::phase_t               ph;
    logic [1:0]                     op;
    logic [3:0]                     bits;
    logic [7:0]                     shreg;
    logic [i2cm_pkg::DELAY_W-1:0]   dly;
    logic [i2cm_pkg::STRETCH_W-1:0] scnt;
    logic                           scl_l;
    logic                           sda_l;
    logic [7:0]                     rx;
    logic                           nak;
    logic                           tmo;
    i2cm_pkg::res_t                 pending_pins[$];
    int                             mismatches;
    int                             checked;
    int                             ticks;
    int                             stretched;
    int                             n_cmds[4];

    function new();
      half_q = i2cm_pkg::HALF_RESET;
      quarter_q = i2cm_pkg::QUARTER_RESET;
      stretch_q = i2cm_pkg::STRETCH_RESET;
      ph = i2cm_pkg::PH_IDLE;
      op = i2cm_pkg::OP_START;
      bits = '0;
      shreg = '0;
      dly = '0;
      scnt = '0;
      scl_l = 1'b1;
      sda_l = 1'b1;
      rx = '0;
      nak = 1'b0;
      tmo = 1'b0;
      mismatches = 0;
      checked = 0;
      ticks = 0;
      stretched = 0;
      n_cmds = '{0, 0, 0, 0};
    endfunction

    function void set_reg(logic [1:0] idx, logic [i2cm_pkg::STRETCH_W-1:0] val);
      case (idx)
        i2cm_pkg::REG_HALF_PERIOD: half_q = val[i2cm_pkg::DELAY_W-1:0];
        i2cm_pkg::REG_QUARTER_PERIOD: quarter_q = val[i2cm_pkg::DELAY_W-1:0];
        i2cm_pkg::REG_STRETCH_LIMIT: stretch_q = val;
        default: ;
      endcase
    endfunction

    function void load_delay(logic [i2cm_pkg::DELAY_W-1:0] v);
      dly = (v == '0) ? 16'd1 : v;
    endfunction

    function bit delay_done();
      if (dly <= 16'd1) begin
        dly = '0;
        return 1'b1;
      end
      dly--;
      return 1'b0;
    endfunction

    function logic drive_level();
      if (bits >= i2cm_pkg::BITS_PER_BYTE) return op != i2cm_pkg::OP_READ;
      if (op == i2cm_pkg::OP_READ) return 1'b1;
      return shreg[7];
    endfunction

    function void take_tick(pin_tick_t t);
      logic                           done;
      logic                           go;
      logic [i2cm_pkg::STRETCH_W-1:0] lim;
      i2cm_pkg::res_t                 want;
      done = 1'b0;
      ticks++;
      case (ph)
        i2cm_pkg::PH_IDLE: if (t.cv) begin
          op = t.op;
          bits = '0;
          scnt = '0;
          n_cmds[t.op]++;
          if (t.op == i2cm_pkg::OP_START) sda_l = 1'b1;
          else if (t.op == i2cm_pkg::OP_STOP) sda_l = 1'b0;
          else begin
            shreg = (t.op == i2cm_pkg::OP_WRITE) ? t.wb : 8'h00;
            sda_l = drive_level();
          end
          load_delay(half_q);
          ph = i2cm_pkg::PH_SETUP;
        end
        i2cm_pkg::PH_SETUP: if (delay_done()) begin
          scl_l = 1'b1;
          scnt = '0;
          ph = i2cm_pkg::PH_RISE;
        end
        i2cm_pkg::PH_RISE: begin
          go = t.scl;
          if (!t.scl) begin
            stretched++;
            lim = (stretch_q == '0) ? 20'd1 : stretch_q;
            scnt = scnt + 1'b1;
            if (scnt >= lim) begin
              tmo = 1'b1;
              go = 1'b1;
            end
          end
          if (go) begin
            load_delay((op == i2cm_pkg::OP_START || op == i2cm_pkg::OP_STOP) ? quarter_q
                                                                           : half_q);
            ph = i2cm_pkg::PH_HIGH;
          end
        end
        i2cm_pkg::PH_HIGH: if (delay_done()) begin
          if (op == i2cm_pkg::OP_START || op == i2cm_pkg::OP_STOP) begin
            sda_l = (op == i2cm_pkg::OP_START) ? 1'b0 : 1'b1;
            load_delay(quarter_q);
            ph = i2cm_pkg::PH_MID;
          end else begin
            if (bits < i2cm_pkg::BITS_PER_BYTE)
              shreg = (op == i2cm_pkg::OP_READ) ? {shreg[6:0], t.sda} : {shreg[6:0], 1'b0};
            else if (op == i2cm_pkg::OP_WRITE)
              nak = t.sda;
            scl_l = 1'b0;
            bits++;
            if (bits > i2cm_pkg::BITS_PER_BYTE) begin
              if (op == i2cm_pkg::OP_READ) rx = shreg;
              bits = '0;
              ph = i2cm_pkg::PH_IDLE;
              done = 1'b1;
            end else begin
              sda_l = drive_level();
              load_delay(half_q);
              ph = i2cm_pkg::PH_SETUP;
            end
          end
        end
        default: if (delay_done()) begin
          scl_l = 1'b0;
          ph = i2cm_pkg::PH_IDLE;
          done = 1'b1;
        end
      endcase
      want = {scl_l, sda_l, ph != i2cm_pkg::PH_IDLE, done, rx, nak, tmo};
      pending_pins.push_back(want);
    endfunction

    function void compare_pins(i2cm_pkg::res_t got);
      i2cm_pkg::res_t want;
      if (pending_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %h arrived with no request outstanding", got);
        return;
      end
      want = pending_pins.pop_front();
      checked++;
      if (got.scl_drive !== want.scl_drive || got.sda_drive !== want.sda_drive ||
          got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
          got.read_byte !== want.read_byte || got.slave_nak !== want.slave_nak ||
          got.stretch_timeout !== want.stretch_timeout) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: tick %0d expected scl %b sda %b busy %b done %b rd %h nak %b",
                    " timeout %b, got scl %b sda %b busy %b done %b rd %h nak %b timeout %b"},
                   checked, want.scl_drive, want.sda_drive, want.busy_res, want.done_res,
                   want.read_byte, want.slave_nak, want.stretch_timeout, got.scl_drive,
                   got.sda_drive, got.busy_res, got.done_res, got.read_byte, got.slave_nak,
                   got.stretch_timeout);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           cmd_valid = 1'b0;
  logic [1:0]                     opcode = i2cm_pkg::OP_START;
  logic [i2cm_pkg::BYTE_W-1:0]    write_byte = '0;
  logic                           scl_sense = 1'b1;
  logic                           sda_sense = 1'b1;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           scl_drive;
  logic                           sda_drive;
  logic                           busy_res;
  logic                           done_res;
  logic [i2cm_pkg::BYTE_W-1:0]    read_byte;
  logic                           slave_nak;
  logic                           stretch_timeout;
  logic                           cfg_we = 1'b0;
  logic [1:0]                     cfg_index = i2cm_pkg::REG_HALF_PERIOD;
  logic [i2cm_pkg::STRETCH_W-1:0] cfg_data = '0;

  engine_model engine;
  bit          hold_wanted = 1'b0;
  int          burst_left = 0;
  int          rise_cnt = 0;
  int          ticks_sent = 0;

  i2c_master_byte_engine u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd_valid(cmd_valid),
    .opcode(opcode),
    .write_byte(write_byte),
    .scl_sense(scl_sense),
    .sda_sense(sda_sense),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .scl_drive(scl_drive),
    .sda_drive(sda_drive),
    .busy_res(busy_res),
    .done_res(done_res),
    .read_byte(read_byte),
    .slave_nak(slave_nak),
    .stretch_timeout(stretch_timeout),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      engine.compare_pins({scl_drive, sda_drive, busy_res, done_res, read_byte, slave_nak,
                           stretch_timeout});
  end

  initial begin : result_stall
    int mode;
    int mode_left;
    int hold_left;
    int period;
    bit s;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    period = 3;
    forever begin
      @(posedge clk);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
        period = $urandom_range(2, 5);
      end
      mode_left--;
      if (hold_left > 0) begin
        s = 1'b1;
        hold_left--;
      end else begin
        case (mode)
          0: s = 1'b0;
          1: s = ($urandom_range(0, 3) == 0);
          2: s = ($urandom_range(0, 9) < 6);
          default: s = ((mode_left % period) == 0);
        endcase
      end
      out_stall <= s;
    end
  end

  task automatic push_tick(input pin_tick_t t);
    int gap;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 250 : $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    cmd_valid <= t.cv;
    opcode <= t.op;
    write_byte <= t.wb;
    scl_sense <= t.scl;
    sda_sense <= t.sda;
    do @(posedge clk); while (in_stall);
    engine.take_tick(t);
    burst_left--;
    ticks_sent++;
  endtask

  // The slave side answers from the predicted phase: SCL is held low for a
  // chosen number of ticks after each release, and SDA carries the data or
  // ACK bit while SCL is high.
  task automatic step(input logic cv, input logic [1:0] op, input logic [7:0] wb,
                      input logic [7:0] rx_bits, input logic ack, input int rise_low);
    pin_tick_t t;
    t.cv = cv;
    t.op = op;
    t.wb = wb;
    if (engine.ph == i2cm_pkg::PH_HIGH)
      t.sda = (engine.bits < i2cm_pkg::BITS_PER_BYTE) ? rx_bits[7 - engine.bits] : ack;
    else
      t.sda = 1'($urandom);
    if (engine.ph == i2cm_pkg::PH_RISE) begin
      t.scl = (rise_cnt >= rise_low);
      rise_cnt++;
    end else begin
      t.scl = 1'($urandom);
      rise_cnt = 0;
    end
    push_tick(t);
  endtask

  task automatic run_cmd(input logic [1:0] op, input logic [7:0] wb, input logic [7:0] rx_bits,
                         input logic ack, input int rise_low, input bit busy_cmds);
    while (engine.ph != i2cm_pkg::PH_IDLE) step(1'b0, op, wb, rx_bits, ack, rise_low);
    step(1'b1, op, wb, rx_bits, ack, rise_low);
    while (engine.ph != i2cm_pkg::PH_IDLE)
      step(busy_cmds && $urandom_range(0, 7) == 0, 2'($urandom), 8'($urandom), rx_bits, ack,
           rise_low);
  endtask

  function automatic int pick_stretch();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 0;
    if (r < 19) return $urandom_range(1, 4);
    return $urandom_range(5, 30);
  endfunction

  task automatic random_cmd(input logic [1:0] op);
    run_cmd(op, 8'($urandom), 8'($urandom), 1'($urandom), pick_stretch(),
            $urandom_range(0, 3) == 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [i2cm_pkg::STRETCH_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    engine.set_reg(idx, val);
  endtask

  task automatic reconfigure(input logic [i2cm_pkg::DELAY_W-1:0] h,
                             input logic [i2cm_pkg::DELAY_W-1:0] q,
                             input logic [i2cm_pkg::STRETCH_W-1:0] s);
    while (engine.ph != i2cm_pkg::PH_IDLE)
      step(1'b0, 2'($urandom), 8'($urandom), 8'h00, 1'b0, 0);
    in_valid <= 1'b0;
    burst_left = 0;
    while (engine.pending_pins.size() != 0) @(posedge clk);
    write_reg(i2cm_pkg::REG_HALF_PERIOD, 20'(h));
    write_reg(i2cm_pkg::REG_QUARTER_PERIOD, 20'(q));
    write_reg(i2cm_pkg::REG_STRETCH_LIMIT, s);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int pass;
    int target;
    engine = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    run_cmd(i2cm_pkg::OP_START, 8'h00, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(i2cm_pkg::OP_WRITE, 8'hA5, 8'h00, 1'b1, 1, 1'b0);
    run_cmd(i2cm_pkg::OP_STOP, 8'h00, 8'h00, 1'b0, 0, 1'b0);

    reconfigure(16'd0, 16'd0, 20'd1000);
    run_cmd(i2cm_pkg::OP_START, 8'h00, 8'h00, 1'b0, 2, 1'b1);
    run_cmd(i2cm_pkg::OP_WRITE, 8'hFF, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(i2cm_pkg::OP_WRITE, 8'h00, 8'hFF, 1'b1, 3, 1'b1);
    run_cmd(i2cm_pkg::OP_READ, 8'h00, 8'hFF, 1'b0, 0, 1'b0);
    run_cmd(i2cm_pkg::OP_READ, 8'hFF, 8'h00, 1'b1, 1, 1'b1);
    run_cmd(i2cm_pkg::OP_READ, 8'h3C, 8'h5A, 1'b0, 0, 1'b1);
    run_cmd(i2cm_pkg::OP_STOP, 8'hFF, 8'h00, 1'b1, 0, 1'b1);

    reconfigure(16'd60, 16'd45, 20'hFFFFF);
    run_cmd(i2cm_pkg::OP_START, 8'h00, 8'h00, 1'b0, 0, 1'b1);

    for (pass = 0; pass < 6; pass++) begin
      if (pass == 3) begin
        // With a zero limit a single low SCL tick already times out.
        reconfigure(16'd1, 16'd1, 20'd0);
        run_cmd(i2cm_pkg::OP_START, 8'h00, 8'h00, 1'b0, 1, 1'b0);
        run_cmd(i2cm_pkg::OP_WRITE, 8'h81, 8'h00, 1'b0, 2, 1'b0);
      end
      reconfigure(16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
                  (pass < 3) ? 20'($urandom_range(40, 1000)) : 20'($urandom_range(0, 6)));
      if (pass == 0 || pass == 3) hold_wanted = 1'b1;
      target = ticks_sent + 100;
      while (ticks_sent < target) begin
        if ($urandom_range(0, 4) == 0) begin
          random_cmd(2'($urandom));
        end else begin
          random_cmd(i2cm_pkg::OP_START);
          random_cmd(i2cm_pkg::OP_WRITE);
          repeat ($urandom_range(1, 3))
            random_cmd($urandom_range(0, 1) ? i2cm_pkg::OP_READ : i2cm_pkg::OP_WRITE);
          random_cmd(i2cm_pkg::OP_STOP);
        end
        repeat ($urandom_range(0, 5))
          step(1'b0, 2'($urandom), 8'($urandom), 8'h00, 1'b0, 0);
      end
    end

    in_valid <= 1'b0;
    while (engine.pending_pins.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d bus ticks with %0d start, %0d stop, %0d read and %0d write commands.",
             engine.ticks, engine.n_cmds[i2cm_pkg::OP_START],
             engine.n_cmds[i2cm_pkg::OP_STOP], engine.n_cmds[i2cm_pkg::OP_READ],
             engine.n_cmds[i2cm_pkg::OP_WRITE]);
    $display("SCL was held low for %0d ticks; the stretch timeout was %s.", engine.stretched,
             engine.tmo ? "reached" : "never reached");
    if (engine.pending_pins.size() != 0)
      $display("ERROR: %0d expected results never arrived", engine.pending_pins.size());
    if (engine.mismatches == 0 && engine.pending_pins.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/i2cm_pkg.sv
design/i2cm_cfg.sv
design/i2cm_core.sv
design/i2c_master_byte_engine.sv
test/i2c_master_byte_engine_tb.sv
